[sv/irtx_pkg.sv]
// Shared types, constants and register map for the IR pulse-width transmitter.
package irtx_pkg;

    // Frame geometry
    localparam int DATA_BITS = 8;
    localparam int BIT_IDX_W = (DATA_BITS > 1) ? $clog2(DATA_BITS) : 1;
    localparam int CMD_W     = 8;
    localparam int CNT_W     = 8;
    localparam int TICK_W    = 12;

    // Configuration port
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = 3;

    // Register indexes (byte address / 4)
    localparam logic [REG_IDX_W-1:0] REG_CARRIER_HIGH = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CARRIER_LOW  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_START_PER    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ONE_PER      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ZERO_PER     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_GAP_TICKS    = 3'd5;

    // Register reset values
    localparam logic [CNT_W-1:0]  RST_CARRIER_HIGH = 8'd7;
    localparam logic [CNT_W-1:0]  RST_CARRIER_LOW  = 8'd20;
    localparam logic [CNT_W-1:0]  RST_START_PER    = 8'd89;
    localparam logic [CNT_W-1:0]  RST_ONE_PER      = 8'd45;
    localparam logic [CNT_W-1:0]  RST_ZERO_PER     = 8'd22;
    localparam logic [TICK_W-1:0] RST_GAP_TICKS    = 12'd600;

    // Transmit phase
    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_START     = 3'd1,
        PH_START_GAP = 3'd2,
        PH_BIT       = 3'd3,
        PH_BIT_GAP   = 3'd4
    } irtx_phase_t;

    // Timing configuration seen by the engine
    typedef struct packed {
        logic [CNT_W-1:0]  carrier_high_ticks;
        logic [CNT_W-1:0]  carrier_low_ticks;
        logic [CNT_W-1:0]  start_periods;
        logic [CNT_W-1:0]  one_periods;
        logic [CNT_W-1:0]  zero_periods;
        logic [TICK_W-1:0] gap_ticks;
    } irtx_cfg_t;

    // One result per tick
    typedef struct packed {
        logic frame_done;
        logic busy_res;
        logic led_on;
    } irtx_res_t;

endpackage

[sv/irtx_regs.sv]
// APB configuration registers for the IR transmitter timing.
module irtx_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [irtx_pkg::APB_AW-1:0]   paddr,
    input  logic [irtx_pkg::APB_DW-1:0]   pwdata,
    output logic [irtx_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output irtx_pkg::irtx_cfg_t           cfg
);
    import irtx_pkg::*;

    irtx_cfg_t              cfg_reg;
    logic                   wr_en;
    logic [REG_IDX_W-1:0]   reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[APB_AW-1:2];
    assign cfg     = cfg_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.carrier_high_ticks <= RST_CARRIER_HIGH;
            cfg_reg.carrier_low_ticks  <= RST_CARRIER_LOW;
            cfg_reg.start_periods      <= RST_START_PER;
            cfg_reg.one_periods        <= RST_ONE_PER;
            cfg_reg.zero_periods       <= RST_ZERO_PER;
            cfg_reg.gap_ticks          <= RST_GAP_TICKS;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_CARRIER_HIGH: cfg_reg.carrier_high_ticks <= pwdata[CNT_W-1:0];
                REG_CARRIER_LOW:  cfg_reg.carrier_low_ticks  <= pwdata[CNT_W-1:0];
                REG_START_PER:    cfg_reg.start_periods      <= pwdata[CNT_W-1:0];
                REG_ONE_PER:      cfg_reg.one_periods        <= pwdata[CNT_W-1:0];
                REG_ZERO_PER:     cfg_reg.zero_periods       <= pwdata[CNT_W-1:0];
                REG_GAP_TICKS:    cfg_reg.gap_ticks          <= pwdata[TICK_W-1:0];
                default:          ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        unique case (reg_idx)
            REG_CARRIER_HIGH: prdata = APB_DW'(cfg_reg.carrier_high_ticks);
            REG_CARRIER_LOW:  prdata = APB_DW'(cfg_reg.carrier_low_ticks);
            REG_START_PER:    prdata = APB_DW'(cfg_reg.start_periods);
            REG_ONE_PER:      prdata = APB_DW'(cfg_reg.one_periods);
            REG_ZERO_PER:     prdata = APB_DW'(cfg_reg.zero_periods);
            REG_GAP_TICKS:    prdata = APB_DW'(cfg_reg.gap_ticks);
            default:          prdata = '0;
        endcase
    end

endmodule

[sv/irtx_engine.sv]
// Frame sequencer: phase, bit and carrier counters, advanced once per accepted tick.
module irtx_engine
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic                          send_request,
    input  logic [irtx_pkg::CMD_W-1:0]    command,
    input  irtx_pkg::irtx_cfg_t           cfg,
    output irtx_pkg::irtx_res_t           res
);
    import irtx_pkg::*;

    localparam logic [BIT_IDX_W:0] LAST_BIT_CNT = (BIT_IDX_W+1)'(DATA_BITS);

    irtx_phase_t            phase_reg, phase_next, phase_eff;
    logic [DATA_BITS-1:0]   shift_reg, shift_next, shift_eff;
    logic [BIT_IDX_W-1:0]   idx_reg, idx_next, idx_eff;
    logic [CNT_W-1:0]       per_reg, per_next, per_eff, per_inc, burst_len;
    logic                   half_reg, half_next, half_eff;
    logic [TICK_W-1:0]      tick_reg, tick_next, tick_eff, tick_inc;
    logic [BIT_IDX_W:0]     idx_inc;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            shift_reg <= '0;
            idx_reg   <= '0;
            per_reg   <= '0;
            half_reg  <= 1'b0;
            tick_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            shift_reg <= shift_next;
            idx_reg   <= idx_next;
            per_reg   <= per_next;
            half_reg  <= half_next;
            tick_reg  <= tick_next;
        end
    end

    // Next state and result for this tick
    always_comb
    begin
        // a request while idle starts the frame on this same tick
        phase_eff = phase_reg;
        shift_eff = shift_reg;
        idx_eff   = idx_reg;
        per_eff   = per_reg;
        half_eff  = half_reg;
        tick_eff  = tick_reg;
        if (phase_reg == PH_IDLE && send_request)
        begin
            phase_eff = PH_START;
            shift_eff = DATA_BITS'(command);
            idx_eff   = '0;
            per_eff   = '0;
            half_eff  = 1'b0;
            tick_eff  = '0;
        end

        tick_inc = tick_eff + 1'b1;
        per_inc  = per_eff + 1'b1;
        idx_inc  = {1'b0, idx_eff} + 1'b1;

        if (phase_eff == PH_START)
            burst_len = cfg.start_periods;
        else if (shift_eff[idx_eff])
            burst_len = cfg.one_periods;
        else
            burst_len = cfg.zero_periods;

        phase_next = phase_eff;
        shift_next = shift_eff;
        idx_next   = idx_eff;
        per_next   = per_eff;
        half_next  = half_eff;
        tick_next  = tick_eff;
        res        = '0;

        unique case (phase_eff) inside
            PH_START, PH_BIT:
            begin
                res.busy_res = 1'b1;
                res.led_on   = ~half_eff;
                tick_next    = tick_inc;
                if (!half_eff)
                begin
                    if (tick_inc >= TICK_W'(cfg.carrier_high_ticks))
                    begin
                        half_next = 1'b1;
                        tick_next = '0;
                    end
                end
                else if (tick_inc >= TICK_W'(cfg.carrier_low_ticks))
                begin
                    // end of one carrier period
                    half_next = 1'b0;
                    tick_next = '0;
                    per_next  = per_inc;
                    if (per_inc >= burst_len)
                    begin
                        phase_next = (phase_eff == PH_START) ? PH_START_GAP : PH_BIT_GAP;
                        per_next   = '0;
                    end
                end
            end
            PH_START_GAP, PH_BIT_GAP:
            begin
                res.busy_res = 1'b1;
                tick_next    = tick_inc;
                if (tick_inc >= cfg.gap_ticks)
                begin
                    tick_next = '0;
                    if (phase_eff == PH_START_GAP)
                    begin
                        phase_next = PH_BIT;
                        idx_next   = '0;
                        per_next   = '0;
                        half_next  = 1'b0;
                    end
                    else if (idx_inc >= LAST_BIT_CNT)
                    begin
                        // last gap of the frame
                        res.frame_done = 1'b1;
                        phase_next     = PH_IDLE;
                        idx_next       = '0;
                    end
                    else
                    begin
                        phase_next = PH_BIT;
                        idx_next   = idx_inc[BIT_IDX_W-1:0];
                        per_next   = '0;
                        half_next  = 1'b0;
                    end
                end
            end
            PH_IDLE:
            begin
                phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

endmodule

[sv/irtx_out_stage.sv]
// Result register between the engine and the output stream.
module irtx_out_stage
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  irtx_pkg::irtx_res_t   res,
    output logic                  can_load,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,
    output logic                  m_tlast
);
    import irtx_pkg::*;

    logic       valid_reg;
    irtx_res_t  res_reg;

    // free when empty or when the held beat leaves this cycle
    assign can_load = ~valid_reg | m_tready;

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (can_load)
            valid_reg <= load;
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'b0, res_reg.busy_res, res_reg.led_on};
    assign m_tlast  = res_reg.frame_done;

endmodule

[sv/ir_pulse_width_transmitter_unit.sv]
// Top level of the IR pulse-width (SIRC-style) command transmitter.
// Each input beat is one microsecond tick and yields exactly one output beat with
// the LED level, the busy flag and the end-of-frame mark (tlast). A tick with tuser
// high while idle latches the command byte and starts the frame on that same tick:
// a start burst, a gap, then eight bits LSB first, each a burst of one- or zero-
// periods and a gap. Throughput is one tick per clock: the frame counters advance on
// every accepted tick and a one-deep result register feeds the output, so s_tready stays
// high unless that register holds a beat the sink is not taking.
// Timing registers (APB, byte address 4*i): carrier high, carrier low, start periods,
// one periods, zero periods, gap ticks. Write them only while no frame is running.
module ir_pulse_width_transmitter_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    // APB configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [irtx_pkg::APB_AW-1:0]   paddr,
    input  logic [irtx_pkg::APB_DW-1:0]   pwdata,
    output logic [irtx_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    // tick input
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] command
    input  logic                          s_tuser,   // [0] send_request
    // result output
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [0] led_on, [1] busy_res, [7:2] zero
    output logic                          m_tlast    // frame_done
);
    import irtx_pkg::*;

    irtx_cfg_t  cfg;
    irtx_res_t  res;
    logic       can_load;
    logic       accept;

    assign s_tready = can_load;
    assign accept   = s_tvalid & can_load;

    irtx_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    irtx_engine u_engine
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (accept),
        .send_request (s_tuser),
        .command      (s_tdata[CMD_W-1:0]),
        .cfg          (cfg),
        .res          (res)
    );

    irtx_out_stage u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .res      (res),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
